FILE: rtl/bfau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfau_pkg
// Types, constants and the microcode table of the binary field arithmetic unit.
// ----------------------------------------------------------------------------
package bfau_pkg;

    localparam int MAX_DEGREE = 32;
    localparam int WORD_W     = 32;
    localparam int DEG_W      = 6;
    localparam int CNT_W      = $clog2(MAX_DEGREE);
    localparam int DIGIT_BITS = 8;
    localparam int NUM_DIGITS = (MAX_DEGREE + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int DIG_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int DIG_SH     = $clog2(DIGIT_BITS);
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int UPC_W      = 4;

    localparam logic [DEG_W-1:0] MIN_DEGREE_C  = DEG_W'(2);
    localparam logic [DEG_W-1:0] MAX_DEGREE_C  = DEG_W'(MAX_DEGREE);
    localparam logic [DEG_W-1:0] DEGREE_RESET  = DEG_W'(8);
    localparam logic [WORD_W-1:0] MODULUS_RESET = WORD_W'(29);

    localparam logic [CFG_IDX_W-1:0] REG_DEGREE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 1'b1;

    localparam logic [MODE_W-1:0] MODE_ADD = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUB = 3'd1;
    localparam logic [MODE_W-1:0] MODE_NEG = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MUL = 3'd3;
    localparam logic [MODE_W-1:0] MODE_INV = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DIV = 3'd5;
    localparam logic [MODE_W-1:0] MODE_EQ  = 3'd6;

    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t UPC_IDLE = 4'd0;
    localparam upc_t UPC_ADD  = 4'd1;
    localparam upc_t UPC_NEG  = 4'd2;
    localparam upc_t UPC_EQ   = 4'd3;
    localparam upc_t UPC_ZERO = 4'd4;
    localparam upc_t UPC_MUL  = 4'd5;
    localparam upc_t UPC_INV  = 4'd6;
    localparam upc_t UPC_DIV  = 4'd7;
    localparam upc_t UPC_SQR  = 4'd8;
    localparam upc_t UPC_MULB = 4'd9;
    localparam upc_t UPC_FIN  = 4'd10;
    localparam upc_t UPC_OUT  = 4'd11;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_XOR,
        ACC_A,
        ACC_EQ,
        ACC_ZERO,
        ACC_ONE,
        ACC_MUL
    } acc_op_t;

    typedef enum logic [2:0] {
        J_NEXT,
        J_ALWAYS,
        J_CNT_ZERO,
        J_OUT,
        J_ACCEPT
    } jmp_t;

    typedef enum logic {
        X_RA,
        X_ACC
    } x_sel_t;

    typedef enum logic {
        Y_RB,
        Y_ACC
    } y_sel_t;

    typedef struct packed {
        acc_op_t acc_op;
        logic    mul_op;
        x_sel_t  x_sel;
        y_sel_t  y_sel;
        logic    b_from_a;
        logic    a_to_one;
        logic    cnt_load;
        logic    cnt_dec;
        jmp_t    jmp;
        upc_t    target;
    } ucw_t;

    typedef struct packed {
        logic accept;
        logic commit;
        logic mul_start;
        logic out_load;
    } seq_ctl_t;

    typedef struct packed {
        logic mul_busy;
        logic mul_done;
        logic cnt_zero;
    } dp_stat_t;

    localparam ucw_t UCW_NOP = '{
        acc_op:   ACC_HOLD,
        mul_op:   1'b0,
        x_sel:    X_RA,
        y_sel:    Y_RB,
        b_from_a: 1'b0,
        a_to_one: 1'b0,
        cnt_load: 1'b0,
        cnt_dec:  1'b0,
        jmp:      J_ALWAYS,
        target:   UPC_IDLE
    };

    function automatic ucw_t ucode_rom(input upc_t pc);
        ucw_t w;
        w = UCW_NOP;
        unique case (pc)
            UPC_IDLE:
            begin
                w.jmp = J_ACCEPT;
            end
            UPC_ADD:
            begin
                w.acc_op = ACC_XOR;
                w.target = UPC_OUT;
            end
            UPC_NEG:
            begin
                w.acc_op = ACC_A;
                w.target = UPC_OUT;
            end
            UPC_EQ:
            begin
                w.acc_op = ACC_EQ;
                w.target = UPC_OUT;
            end
            UPC_ZERO:
            begin
                w.acc_op = ACC_ZERO;
                w.target = UPC_OUT;
            end
            UPC_MUL:
            begin
                w.acc_op = ACC_MUL;
                w.mul_op = 1'b1;
                w.target = UPC_OUT;
            end
            UPC_INV:
            begin
                w.b_from_a = 1'b1;
                w.a_to_one = 1'b1;
                w.jmp      = J_NEXT;
            end
            UPC_DIV:
            begin
                w.acc_op   = ACC_ONE;
                w.cnt_load = 1'b1;
                w.jmp      = J_NEXT;
            end
            UPC_SQR:
            begin
                w.acc_op = ACC_MUL;
                w.mul_op = 1'b1;
                w.x_sel  = X_ACC;
                w.y_sel  = Y_ACC;
                w.jmp    = J_CNT_ZERO;
                w.target = UPC_FIN;
            end
            UPC_MULB:
            begin
                w.acc_op  = ACC_MUL;
                w.mul_op  = 1'b1;
                w.x_sel   = X_ACC;
                w.y_sel   = Y_RB;
                w.cnt_dec = 1'b1;
                w.target  = UPC_SQR;
            end
            UPC_FIN:
            begin
                w.acc_op = ACC_MUL;
                w.mul_op = 1'b1;
                w.x_sel  = X_RA;
                w.y_sel  = Y_ACC;
                w.target = UPC_OUT;
            end
            UPC_OUT:
            begin
                w.jmp    = J_OUT;
                w.target = UPC_IDLE;
            end
            default:
            begin
                w = UCW_NOP;
            end
        endcase
        return w;
    endfunction

    function automatic upc_t dispatch(input logic [MODE_W-1:0] mode);
        upc_t pc;
        unique case (mode)
            MODE_ADD, MODE_SUB: pc = UPC_ADD;
            MODE_NEG:           pc = UPC_NEG;
            MODE_MUL:           pc = UPC_MUL;
            MODE_INV:           pc = UPC_INV;
            MODE_DIV:           pc = UPC_DIV;
            MODE_EQ:            pc = UPC_EQ;
            default:            pc = UPC_ZERO;
        endcase
        return pc;
    endfunction

endpackage

FILE: rtl/bfau_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfau_mul
// Digit-serial field multiplier, one byte of the second operand per cycle.
// ----------------------------------------------------------------------------
module bfau_mul
    import bfau_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] x,
    input  logic [WORD_W-1:0] y,
    input  logic [CNT_W-1:0]  n_m1,
    input  logic [WORD_W-1:0] mask,
    input  logic [WORD_W-1:0] low,
    output logic              busy,
    output logic              done,
    output logic [WORD_W-1:0] product
);

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [DIG_W-1:0]  dig_reg;
    logic [DIG_W-1:0]  dig_next;
    logic [WORD_W-1:0] x_reg;
    logic [WORD_W-1:0] x_next;
    logic [WORD_W-1:0] y_reg;
    logic [WORD_W-1:0] y_next;
    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] acc_next;
    logic [WORD_W-1:0] step_val;

    always_comb
    begin
        logic [WORD_W-1:0]     v;
        logic [DIGIT_BITS-1:0] yd;
        logic                  top;
        v  = acc_reg;
        yd = DIGIT_BITS'(y_reg >> (32'(dig_reg) * DIGIT_BITS));
        for (int j = DIGIT_BITS - 1; j >= 0; j--)
        begin
            top = v[n_m1];
            v   = (v << 1) & mask;
            if (top)
            begin
                v = v ^ low;
            end
            if (yd[j])
            begin
                v = v ^ x_reg;
            end
        end
        step_val = v;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        dig_next  = dig_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            dig_next  = DIG_W'(n_m1 >> DIG_SH);
            x_next    = x;
            y_next    = y;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = step_val;
            if (dig_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                dig_next = dig_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = acc_reg;

endmodule

FILE: rtl/bfau_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfau_dp
// Datapath: configuration, operand, accumulator, loop count and result words.
// ----------------------------------------------------------------------------
module bfau_dp
    import bfau_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    input  logic [WORD_W-1:0]    operand_a,
    input  logic [WORD_W-1:0]    operand_b,
    input  seq_ctl_t             ctl,
    input  ucw_t                 cw,
    output dp_stat_t             stat,
    output logic [WORD_W-1:0]    result
);

    logic [DEG_W-1:0]  degree_reg;
    logic [DEG_W-1:0]  degree_next;
    logic [WORD_W-1:0] modulus_reg;
    logic [WORD_W-1:0] modulus_next;
    logic [WORD_W-1:0] ra_reg;
    logic [WORD_W-1:0] ra_next;
    logic [WORD_W-1:0] rb_reg;
    logic [WORD_W-1:0] rb_next;
    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] acc_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [WORD_W-1:0] result_reg;
    logic [WORD_W-1:0] result_next;
    logic [DEG_W-1:0]  n_eff;
    logic [CNT_W-1:0]  n_m1;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] low;
    logic [WORD_W-1:0] mul_x;
    logic [WORD_W-1:0] mul_y;
    logic [WORD_W-1:0] product;
    logic              mul_busy;
    logic              mul_done;

    always_comb
    begin
        priority if (degree_reg < MIN_DEGREE_C)
        begin
            n_eff = MIN_DEGREE_C;
        end
        else if (degree_reg > MAX_DEGREE_C)
        begin
            n_eff = MAX_DEGREE_C;
        end
        else
        begin
            n_eff = degree_reg;
        end
    end

    assign n_m1  = CNT_W'(n_eff - 1'b1);
    assign mask  = ~({WORD_W{1'b1}} << n_eff);
    assign low   = modulus_reg & mask;
    assign mul_x = (cw.x_sel == X_RA) ? ra_reg : acc_reg;
    assign mul_y = (cw.y_sel == Y_RB) ? rb_reg : acc_reg;

    bfau_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ctl.mul_start),
        .x       (mul_x),
        .y       (mul_y),
        .n_m1    (n_m1),
        .mask    (mask),
        .low     (low),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (product)
    );

    always_comb
    begin
        degree_next  = degree_reg;
        modulus_next = modulus_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DEGREE:  degree_next  = cfg_data[DEG_W-1:0];
                REG_MODULUS: modulus_next = cfg_data;
                default:     degree_next  = degree_reg;
            endcase
        end
    end

    always_comb
    begin
        ra_next     = ra_reg;
        rb_next     = rb_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        result_next = result_reg;
        if (ctl.accept)
        begin
            ra_next = operand_a & mask;
            rb_next = operand_b & mask;
        end
        if (ctl.commit)
        begin
            if (cw.a_to_one)
            begin
                ra_next = WORD_W'(1);
            end
            if (cw.b_from_a)
            begin
                rb_next = ra_reg;
            end
            if (cw.cnt_load)
            begin
                cnt_next = n_m1;
            end
            else if (cw.cnt_dec)
            begin
                cnt_next = cnt_reg - 1'b1;
            end
            unique case (cw.acc_op)
                ACC_HOLD: acc_next = acc_reg;
                ACC_XOR:  acc_next = ra_reg ^ rb_reg;
                ACC_A:    acc_next = ra_reg;
                ACC_EQ:   acc_next = WORD_W'(ra_reg == rb_reg);
                ACC_ZERO: acc_next = '0;
                ACC_ONE:  acc_next = WORD_W'(1);
                ACC_MUL:  acc_next = product;
                default:  acc_next = acc_reg;
            endcase
        end
        if (ctl.out_load)
        begin
            result_next = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg  <= DEGREE_RESET;
            modulus_reg <= MODULUS_RESET;
        end
        else
        begin
            degree_reg  <= degree_next;
            modulus_reg <= modulus_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        acc_reg    <= acc_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

    assign stat.mul_busy = mul_busy;
    assign stat.mul_done = mul_done;
    assign stat.cnt_zero = (cnt_reg == '0);
    assign result        = result_reg;

endmodule

FILE: rtl/bfau_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfau_seq
// Microcode sequencer: step counter, control store, jumps and handshakes.
// ----------------------------------------------------------------------------
module bfau_seq
    import bfau_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [MODE_W-1:0] mode,
    input  logic              out_stall,
    input  dp_stat_t          stat,
    output logic              in_stall,
    output logic              out_valid,
    output seq_ctl_t          ctl,
    output ucw_t              cw
);

    upc_t pc_reg;
    upc_t pc_next;
    logic mul_wait_reg;
    logic mul_wait_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic done;

    always_comb
    begin
        cw             = ucode_rom(pc_reg);
        ctl            = '0;
        done           = 1'b0;
        pc_next        = pc_reg;
        mul_wait_next  = mul_wait_reg;
        out_valid_next = out_valid_reg & out_stall;
        priority if (cw.jmp == J_ACCEPT)
        begin
            done       = in_valid;
            ctl.accept = in_valid;
        end
        else if (cw.mul_op)
        begin
            if (!mul_wait_reg)
            begin
                ctl.mul_start = 1'b1;
                mul_wait_next = 1'b1;
            end
            else if (stat.mul_done)
            begin
                done          = 1'b1;
                mul_wait_next = 1'b0;
            end
        end
        else if (cw.jmp == J_OUT)
        begin
            done         = !out_valid_reg || !out_stall;
            ctl.out_load = done;
            if (done)
            begin
                out_valid_next = 1'b1;
            end
        end
        else
        begin
            done = 1'b1;
        end
        ctl.commit = done && (cw.jmp != J_ACCEPT);
        if (done)
        begin
            unique case (cw.jmp)
                J_NEXT:          pc_next = pc_reg + 1'b1;
                J_ALWAYS, J_OUT: pc_next = cw.target;
                J_CNT_ZERO:      pc_next = stat.cnt_zero ? cw.target : pc_reg + 1'b1;
                J_ACCEPT:        pc_next = dispatch(mode);
                default:         pc_next = UPC_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= UPC_IDLE;
            mul_wait_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            mul_wait_reg  <= mul_wait_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (cw.jmp != J_ACCEPT);
    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/binary_field_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_field_arithmetic_unit
// Polynomial-basis GF(2^n) unit: add/subtract, negate, multiply, invert, divide, compare.
// ----------------------------------------------------------------------------
//  Channel   Signals                             Direction
//  input     in_valid, in_stall, mode,           words in
//            operand_a, operand_b
//  output    out_valid, out_stall, result        words out
//  config    cfg_write, cfg_index, cfg_data      register writes
//
// One word is worked on at a time. With D = ceil(n/8), each multiplication
// runs through D bytes in the byte-serial multiplier, which sets the pace;
// inverse and divide raise the divisor to the power 2^n - 2 by n squarings
// and n - 1 multiplications, then multiply by the dividend. Reset loads
// degree 8 and modulus low bits 29 and idles the sequencer. The finished word
// waits in the result register while the next input word is taken; a held
// result stalls the sequencer only when the following result is ready.
// ----------------------------------------------------------------------------
module binary_field_arithmetic_unit
    import bfau_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [MODE_W-1:0]    mode,
    input  logic [WORD_W-1:0]    operand_a,
    input  logic [WORD_W-1:0]    operand_b,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [WORD_W-1:0]    result
);

    seq_ctl_t ctl;
    ucw_t     cw;
    dp_stat_t stat;

    bfau_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .mode      (mode),
        .out_stall (out_stall),
        .stat      (stat),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .ctl       (ctl),
        .cw        (cw)
    );

    bfau_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .ctl       (ctl),
        .cw        (cw),
        .stat      (stat),
        .result    (result)
    );

    // The multiplier is never running while the sequencer waits for a word.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !stat.mul_busy)
        else $error("multiplier busy while sequencer is idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.mul_start |-> !stat.mul_busy)
        else $error("multiplier started while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.accept |=> in_stall)
        else $error("sequencer did not leave idle after taking a word");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(ctl.out_load))
        else $error("result valid without a result load");

endmodule
